// File: rtl/core/kda_pkg.sv
// Package for the key debounce and autorepeat block: word types, codes and reset values.
`default_nettype none

package kda_pkg;

  localparam int KEY_COUNT_DEF    = 8;
  localparam int HISTORY_BITS_DEF = 4;

  localparam int CMD_W   = 2;
  localparam int KEY_IW  = 3;
  localparam int EVENT_W = 3;
  localparam int CNT_W   = 8;
  localparam int MODE_W  = 4;
  localparam int REG_IW  = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PAUSE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_KILL  = 2'd2;

  // per-key modes
  localparam logic [MODE_W-1:0] MODE_OFF    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_START  = 4'd1;
  localparam logic [MODE_W-1:0] MODE_DELAY  = 4'd2;
  localparam logic [MODE_W-1:0] MODE_PAUSED = 4'd3;
  localparam logic [MODE_W-1:0] MODE_KILLED = 4'd4;
  localparam logic [MODE_W-1:0] MODE_RPT16  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_RPT8   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_RPT4   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_RPT2   = 4'd8;
  localparam logic [MODE_W-1:0] MODE_RPT1   = 4'd9;

  // event kinds
  localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EVENT_W-1:0] EV_FIRST   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_LONG    = 3'd2;
  localparam logic [EVENT_W-1:0] EV_REPEAT  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_RELEASE = 3'd4;

  // register indexes
  localparam logic [REG_IW-1:0] REG_LONG_PRESS   = 2'd0;
  localparam logic [REG_IW-1:0] REG_FIRST_REPEAT = 2'd1;
  localparam logic [REG_IW-1:0] REG_LEVEL        = 2'd2;
  localparam logic [REG_IW-1:0] REG_PAUSE        = 2'd3;

  // register reset values
  localparam logic [CNT_W-1:0] LONG_PRESS_RST   = 8'd32;
  localparam logic [CNT_W-1:0] FIRST_REPEAT_RST = 8'd40;
  localparam logic [CNT_W-1:0] LEVEL_RST        = 8'd48;
  localparam logic [CNT_W-1:0] PAUSE_RST        = 8'd64;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_IW-1:0] key_index;
    logic              key_level;
  } in_word_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_kind;
    logic [KEY_IW-1:0]  event_key;
  } out_word_t;

endpackage

`default_nettype wire

// File: rtl/core/key_debounce_autorepeat.sv
// Top level: per-key debounce with first-press, long-press, repeat and release events.
`default_nettype none

// Channel  | Direction | Handshake             | Word
// ---------+-----------+-----------------------+--------------------------------------
// in       | into      | in_valid / in_ready   | in_data: cmd, key_index, key_level
// out      | out of    | out_valid / out_ready | out_data: event_kind, event_key
// cfg      | into      | cfg_valid / cfg_ready | cfg_index, cfg_data (8-bit register)
//
// Each input word gives exactly one output word. An accepted word sits in the input
// register while one pass of the per-key update logic loads the output register, so
// out_valid rises once the word has gone through the input register and then the
// output register. Throughput is one word per cycle while the output is not stalled;
// the limit is the single read-modify-write of the addressed key's history, count and mode.
// Synchronous reset clears all key state and loads the register defaults.
// A stalled output holds the processed word; the input register still takes one
// more word, then in_ready drops until the output drains. cfg_ready is always high.

module key_debounce_autorepeat
  import kda_pkg::*;
#(
  parameter int KEY_COUNT    = KEY_COUNT_DEF,
  parameter int HISTORY_BITS = HISTORY_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_word_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_word_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [REG_IW-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]  cfg_data
);

  localparam int KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int KWIDE = KEY_W + KEY_IW;

  // configuration registers
  logic [CNT_W-1:0] long_press_ticks;
  logic [CNT_W-1:0] first_repeat_ticks;
  logic [CNT_W-1:0] level_ticks;
  logic [CNT_W-1:0] pause_ticks;

  // per-key state
  logic [HISTORY_BITS-1:0] sample_history [KEY_COUNT];
  logic [CNT_W-1:0]        tick_count     [KEY_COUNT];
  logic [MODE_W-1:0]       key_mode       [KEY_COUNT];

  // input register
  logic     in_full;
  in_word_t in_word;

  logic proc_fire;

  // addressed key
  logic [KWIDE-1:0] key_wide;
  logic [KEY_W-1:0] key_sel;
  logic             key_ok;

  // update logic
  logic [HISTORY_BITS-1:0] hist_shift;
  logic [MODE_W-1:0]       mode_cur;
  logic [MODE_W-1:0]       mode_next;
  logic [CNT_W-1:0]        count_next;
  logic [HISTORY_BITS-1:0] history_next;
  logic [EVENT_W-1:0]      event_next;
  logic                    rpt_hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks   <= LONG_PRESS_RST;
      first_repeat_ticks <= FIRST_REPEAT_RST;
      level_ticks        <= LEVEL_RST;
      pause_ticks        <= PAUSE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LONG_PRESS:   long_press_ticks   <= cfg_data;
        REG_FIRST_REPEAT: first_repeat_ticks <= cfg_data;
        REG_LEVEL:        level_ticks        <= cfg_data;
        REG_PAUSE:        pause_ticks        <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Process the held word whenever the output register is free or being emptied.
  assign proc_fire = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word <= in_data;
    end
  end

  assign key_wide = {{KEY_W{1'b0}}, in_word.key_index};
  assign key_sel  = key_wide[KEY_W-1:0];
  assign key_ok   = key_wide < KWIDE'(KEY_COUNT);

  // Next state of the addressed key and the event it gives.
  always_comb begin
    hist_shift   = {sample_history[key_sel][HISTORY_BITS-2:0], in_word.key_level};
    mode_cur     = key_mode[key_sel];
    mode_next    = mode_cur;
    count_next   = tick_count[key_sel];
    history_next = sample_history[key_sel];
    event_next   = EV_NONE;
    rpt_hit      = 1'b0;

    unique case (in_word.cmd)
      CMD_TICK: begin
        history_next = hist_shift;
        count_next   = tick_count[key_sel] + CNT_W'(1);
        // codes past the top repeat speed never occur; treat them as off
        if (mode_cur > MODE_RPT1) begin
          mode_next = MODE_OFF;
        end
        // settled release ends whatever the key was doing
        if (mode_next != MODE_OFF && hist_shift == '0) begin
          if (mode_next != MODE_KILLED) begin
            event_next = EV_RELEASE;
          end
          count_next = '0;
          mode_next  = MODE_OFF;
        end

        unique case (mode_next) inside
          MODE_OFF: begin
            if (hist_shift == '1) begin
              mode_next  = MODE_START;
              count_next = '0;
            end
          end
          MODE_START: begin
            event_next = EV_FIRST;
            mode_next  = MODE_DELAY;
            count_next = '0;
          end
          MODE_DELAY: begin
            if (count_next == long_press_ticks) begin
              event_next = EV_LONG;
            end
            if (count_next == first_repeat_ticks) begin
              mode_next  = MODE_RPT16;
              count_next = '0;
            end
          end
          MODE_PAUSED: begin
            if (count_next >= pause_ticks) begin
              mode_next  = MODE_RPT8;
              count_next = '0;
            end
          end
          [MODE_RPT16:MODE_RPT1]: begin
            if (mode_next != MODE_RPT1 && count_next >= level_ticks) begin
              mode_next  = mode_next + MODE_W'(1);
              count_next = '0;
            end
            unique case (mode_next)
              MODE_RPT16: rpt_hit = count_next[3:0] == 4'd0;
              MODE_RPT8:  rpt_hit = count_next[2:0] == 3'd0;
              MODE_RPT4:  rpt_hit = count_next[1:0] == 2'd0;
              MODE_RPT2:  rpt_hit = !count_next[0];
              default:    rpt_hit = 1'b1;
            endcase
            if (rpt_hit) begin
              event_next = EV_REPEAT;
            end
          end
          default: ;  // killed: silent until release
        endcase
      end
      CMD_PAUSE: begin
        mode_next  = MODE_PAUSED;
        count_next = '0;
      end
      CMD_KILL: begin
        mode_next = MODE_KILLED;
      end
      default: ;
    endcase

    if (!key_ok) begin
      event_next = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        sample_history[i] <= '0;
        tick_count[i]     <= '0;
        key_mode[i]       <= MODE_OFF;
      end
    end else if (proc_fire && key_ok) begin
      sample_history[key_sel] <= history_next;
      tick_count[key_sel]     <= count_next;
      key_mode[key_sel]       <= mode_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_data.event_kind <= event_next;
      out_data.event_key  <= in_word.key_index;
    end
  end

  // Commands other than a tick never give an event.
  a_cmd_silent: assert property (@(posedge clk) disable iff (rst)
    proc_fire && in_word.cmd != CMD_TICK |=> out_data.event_kind == EV_NONE)
    else $error("event from a non-tick command");

  // A pause leaves the key paused.
  a_pause_mode: assert property (@(posedge clk) disable iff (rst)
    proc_fire && key_ok && in_word.cmd == CMD_PAUSE |=>
      key_mode[$past(key_sel)] == MODE_PAUSED)
    else $error("pause did not set paused mode");

  // A killed key never reports its release.
  a_killed_quiet: assert property (@(posedge clk) disable iff (rst)
    proc_fire && key_ok && in_word.cmd == CMD_TICK && key_mode[key_sel] == MODE_KILLED
      |=> out_data.event_kind != EV_RELEASE)
    else $error("release event from a killed key");

  // Modes stay within the defined codes.
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    proc_fire && key_ok |=> key_mode[$past(key_sel)] <= MODE_RPT1)
    else $error("mode code out of range");

endmodule

`default_nettype wire

// File: sim/tb.sv
// Testbench for key_debounce_autorepeat: predicts each key event and checks the output words.
`timescale 1ns / 1ps

module tb;
  import kda_pkg::*;

  // unused command code, must give a none event and leave key state alone
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // cycles with no handshake on any channel before giving up
  localparam int QUIET_LIMIT = 2000;
  localparam int KEYS = KEY_COUNT_DEF;
  localparam int HIST = HISTORY_BITS_DEF;

  // Holds its own copy of every key's history, count and mode plus the four
  // registers, and keeps the event words still owed by the block, oldest first.
  class key_event_scoreboard;
    logic [HIST-1:0]   hist [KEYS];
    logic [CNT_W-1:0]  ticks [KEYS];
    logic [MODE_W-1:0] mode [KEYS];
    logic [CNT_W-1:0]  long_press, first_repeat, level_len, pause_len;
    out_word_t         due_events [$];
    int                errors;

    function new();
      for (int k = 0; k < KEYS; k++) begin
        hist[k]  = '0;
        ticks[k] = '0;
        mode[k]  = MODE_OFF;
      end
      long_press   = LONG_PRESS_RST;
      first_repeat = FIRST_REPEAT_RST;
      level_len    = LEVEL_RST;
      pause_len    = PAUSE_RST;
      errors       = 0;
    endfunction

    function void write_reg(logic [REG_IW-1:0] idx, logic [CNT_W-1:0] val);
      case (idx)
        REG_LONG_PRESS:   long_press   = val;
        REG_FIRST_REPEAT: first_repeat = val;
        REG_LEVEL:        level_len    = val;
        REG_PAUSE:        pause_len    = val;
        default: ;
      endcase
    endfunction

    // One sample tick of key k: shift level in, bump the count, step the mode.
    function logic [EVENT_W-1:0] sample_key(int k, logic lvl);
      logic [HIST-1:0]    h;
      logic [CNT_W-1:0]   cnt;
      logic [MODE_W-1:0]  m;
      logic [EVENT_W-1:0] ev;
      int                 spacing;
      ev  = EV_NONE;
      h   = {hist[k][HIST-2:0], lvl};
      cnt = ticks[k] + 1'b1;
      m   = mode[k];
      if (m > MODE_RPT1) m = MODE_OFF;
      // all-zero history ends any activity; killed keys stay silent
      if (m != MODE_OFF && h == '0) begin
        if (m != MODE_KILLED) ev = EV_RELEASE;
        cnt = '0;
        m   = MODE_OFF;
      end
      case (m)
        MODE_OFF: begin
          if (h == '1) begin
            m   = MODE_START;
            cnt = '0;
          end
        end
        MODE_START: begin
          ev  = EV_FIRST;
          m   = MODE_DELAY;
          cnt = '0;
        end
        MODE_DELAY: begin
          if (cnt == long_press) ev = EV_LONG;
          if (cnt == first_repeat) begin
            m   = MODE_RPT16;
            cnt = '0;
          end
        end
        MODE_PAUSED: begin
          if (cnt >= pause_len) begin
            m   = MODE_RPT8;
            cnt = '0;
          end
        end
        MODE_KILLED: ;
        default: begin
          // repeating: halve the spacing once the level timer runs out
          if (m < MODE_RPT1 && cnt >= level_len) begin
            m   = m + 1'b1;
            cnt = '0;
          end
          spacing = 1 << (MODE_RPT1 - m);
          if ((cnt & CNT_W'(spacing - 1)) == '0) ev = EV_REPEAT;
        end
      endcase
      hist[k]  = h;
      ticks[k] = cnt;
      mode[k]  = m;
      return ev;
    endfunction

    // Accepted input word: update the key and queue the event it owes.
    function void note_word(in_word_t w);
      out_word_t e;
      e.event_kind = EV_NONE;
      e.event_key  = w.key_index;
      case (w.cmd)
        CMD_TICK:  e.event_kind = sample_key(w.key_index, w.key_level);
        CMD_PAUSE: begin
          mode[w.key_index]  = MODE_PAUSED;
          ticks[w.key_index] = '0;
        end
        CMD_KILL:  mode[w.key_index] = MODE_KILLED;
        default: ;
      endcase
      due_events.push_back(e);
    endfunction

    task report(string msg);
      if (errors < 40) $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (due_events.size() == 0) begin
        report($sformatf("unexpected word kind %0d key %0d", got.event_kind, got.event_key));
      end else begin
        want = due_events.pop_front();
        if (got.event_kind !== want.event_kind)
          report($sformatf("event_kind %0d, want %0d (key %0d)",
                           got.event_kind, want.event_kind, want.event_key));
        if (got.event_key !== want.event_key)
          report($sformatf("event_key %0d, want %0d", got.event_key, want.event_key));
      end
    endtask
  endclass

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_word_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [REG_IW-1:0] cfg_index = REG_LONG_PRESS;
  logic [CNT_W-1:0]  cfg_data  = '0;

  key_event_scoreboard board;

  // idling knobs: chance of a gap before an input word, chance per cycle of an
  // output stall; calm turns both off for the tail of the run
  int gap_pct    = 0;
  int stall_pct  = 0;
  int stall_left = 0;
  bit calm       = 1'b0;
  int quiet_cycles = 0;

  key_debounce_autorepeat dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output side: random stall bursts
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // every event word goes against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_word(out_data);
  end

  // watchdog: no handshake on any channel for too long means a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[key_debounce_autorepeat] ERROR");
      $finish;
    end
  end

  // One input word; may sit out a random gap first. Valid stays up until taken.
  task automatic put_word(in_word_t w);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(w);
  endtask

  task automatic put_fields(logic [CMD_W-1:0] c, int k, logic lvl);
    in_word_t w;
    w.cmd       = c;
    w.key_index = KEY_IW'(k);
    w.key_level = lvl;
    put_word(w);
  endtask

  // Stop input and wait for every owed word, then let the block go idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.due_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four registers back to back, valid held high across them.
  task automatic set_regs(logic [CNT_W-1:0] lp, logic [CNT_W-1:0] fr,
                          logic [CNT_W-1:0] lv, logic [CNT_W-1:0] ps);
    logic [REG_IW-1:0] regs [4];
    logic [CNT_W-1:0]  vals [4];
    regs = '{REG_LONG_PRESS, REG_FIRST_REPEAT, REG_LEVEL, REG_PAUSE};
    vals = '{lp, fr, lv, ps};
    for (int i = 0; i < 4; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      board.write_reg(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // A settings phase: registers, idling mix, then n random words. Most words go to
  // one focus key whose target level flips only now and then, so held keys get
  // deep into delay and repeat; the rest is other keys, bounce noise and commands.
  task automatic run_phase(logic [CNT_W-1:0] lp, logic [CNT_W-1:0] fr,
                           logic [CNT_W-1:0] lv, logic [CNT_W-1:0] ps,
                           int n, int focus_pct, int toggle_odds, int ctrl_pct);
    in_word_t       w;
    logic [KEYS-1:0] held;
    int             focus;
    int             k;
    int             r;
    drain();
    set_regs(lp, fr, lv, ps);
    gap_pct   = $urandom_range(0, 2) * 20;
    stall_pct = $urandom_range(0, 2) * 10;
    focus     = $urandom_range(0, KEYS - 1);
    held      = KEYS'($urandom);
    held[focus] = 1'b1;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(0, 99) < focus_pct) ? focus : $urandom_range(0, KEYS - 1);
      if ($urandom_range(0, toggle_odds - 1) == 0) held[k] = ~held[k];
      r = $urandom_range(0, 99);
      if (r < ctrl_pct)                w.cmd = CMD_PAUSE;
      else if (r < 2 * ctrl_pct)       w.cmd = CMD_KILL;
      else if (r < 2 * ctrl_pct + 2)   w.cmd = CMD_UNUSED;
      else                             w.cmd = CMD_TICK;
      w.key_index = k[KEY_IW-1:0];
      // occasional bounce against the held level
      w.key_level = ($urandom_range(0, 19) == 0) ? ~held[k] : held[k];
      put_word(w);
    end
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset register values
    // key 7: four high samples arm it, fifth gives first press
    repeat (5) put_fields(CMD_TICK, 7, 1'b1);
    // pause of an up key: next all-zero sample releases it with an event
    put_fields(CMD_PAUSE, 0, 1'b0);
    put_fields(CMD_TICK, 0, 1'b0);
    // kill of an up key: next all-zero sample returns it to off silently
    put_fields(CMD_KILL, 1, 1'b0);
    put_fields(CMD_TICK, 1, 1'b0);
    // unused command gives a none event and changes no key
    put_fields(CMD_UNUSED, 2, 1'b1);
    // pause a held key, then kill it; its release stays silent
    put_fields(CMD_PAUSE, 7, 1'b1);
    repeat (2) put_fields(CMD_TICK, 7, 1'b1);
    put_fields(CMD_KILL, 7, 1'b1);
    repeat (4) put_fields(CMD_TICK, 7, 1'b0);
    // bounce on key 3 never settles
    put_fields(CMD_TICK, 3, 1'b1);
    put_fields(CMD_TICK, 3, 1'b0);
    put_fields(CMD_TICK, 3, 1'b1);
    put_fields(CMD_TICK, 3, 1'b1);

    // short timers, all events come fast
    run_phase(8'd3, 8'd6, 8'd4, 8'd5, 130, 75, 40, 3);
    // low extremes: no long press, level timer zero halves every tick
    run_phase(8'd0, 8'd1, 8'd0, 8'd0, 120, 75, 60, 3);
    // high extremes: one key held through the whole delay
    run_phase(8'd255, 8'd255, 8'd255, 8'd255, 350, 92, 2000, 0);
    // first repeat zero waits for the count to wrap; pause at its maximum
    run_phase(8'd2, 8'd0, 8'd1, 8'd255, 160, 75, 300, 2);
    // random settings, no idling on either side to finish
    calm = 1'b1;
    run_phase(CNT_W'($urandom_range(0, 40)), CNT_W'($urandom_range(1, 40)),
              CNT_W'($urandom_range(0, 30)), CNT_W'($urandom_range(0, 30)),
              150, 70, 50, 3);

    drain();
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("[key_debounce_autorepeat] OK");
    end else begin
      $display("[key_debounce_autorepeat] ERROR");
    end
    $finish;
  end

endmodule
